// File: hw/rtl/gccc_pkg.sv
// Shared types, widths, codes and lookup tables of the correlator channel.
// No dependencies; used by the chip-index unit and the top level.
`default_nettype none

package gccc_pkg;

	// Default spreading code length in chips
	localparam int unsigned CODE_LENGTH_DEF = 10230;
	// Entries of the carrier sine/cosine tables
	localparam int unsigned PHASE_TABLE_SIZE = 16;
	localparam int unsigned TRIG_IDX_W = $clog2(PHASE_TABLE_SIZE);

	// Word field widths
	localparam int unsigned SAMPLE_W    = 4;
	localparam int unsigned CHIP_ADDR_W = 14;
	localparam int unsigned ACC_W       = 32;
	localparam int unsigned EPOCH_W     = 17;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 152;

	// Register widths
	localparam int unsigned ADC_W      = 2;
	localparam int unsigned GEO_W      = 2;
	localparam int unsigned CARR_W     = 30;
	localparam int unsigned CODE_W     = 63;
	localparam int unsigned SPACING_W  = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 63;
	localparam logic [SPACING_W-1:0] SPACING_RST = 5'd16;

	// Code NCO: 64-bit phase, upper word counts 1/256 chip
	localparam int unsigned PHASE_W    = 64;
	localparam int unsigned HI_W       = 32;
	localparam int unsigned FRAC_BITS  = 8;
	localparam int unsigned SUB_W      = 5;	// 1/32 chip position inside a chip
	localparam int unsigned CHIP_IDX_W = HI_W - FRAC_BITS;

	// Reciprocal scaling of the chip-index reduction
	localparam int unsigned RECIP_SHIFT = 34;

	// Epoch counter limits
	localparam int unsigned EPOCH_LO_W   = 6;
	localparam logic [EPOCH_LO_W-1:0] LO_LIMIT_2MS = 6'd2;
	localparam logic [EPOCH_LO_W-1:0] LO_LIMIT_1MS = 6'd20;
	localparam logic [9:0] HI_LIMIT_2MS = 10'd500;
	localparam logic [6:0] HI_LIMIT_1MS = 7'd50;

	// Item kinds carried in tuser
	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_CHIP   = 1'b1
	} cmd_t;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE  = 3'd0,
		REG_ADC     = 3'd1,
		REG_GEO     = 3'd2,
		REG_CARRIER = 3'd3,
		REG_CODE    = 3'd4,
		REG_SPACING = 3'd5
	} cfg_idx_t;

	// Sample quantizer modes
	localparam logic [ADC_W-1:0] ADC_ONE_BIT = 2'd0;
	localparam logic [ADC_W-1:0] ADC_TWO_BIT = 2'd1;

	// Epoch counting classes
	localparam logic [GEO_W-1:0] GEO_2MS = 2'd0;
	localparam logic [GEO_W-1:0] GEO_1MS = 2'd1;

	// Sine of the carrier phase sector center, scaled by 8
	function automatic logic signed [4:0] sin_lut(input logic [TRIG_IDX_W-1:0] idx);
		case (idx)
			4'd0:    return 5'sd2;
			4'd1:    return 5'sd5;
			4'd2:    return 5'sd7;
			4'd3:    return 5'sd8;
			4'd4:    return 5'sd8;
			4'd5:    return 5'sd7;
			4'd6:    return 5'sd5;
			4'd7:    return 5'sd2;
			4'd8:    return -5'sd2;
			4'd9:    return -5'sd5;
			4'd10:   return -5'sd7;
			4'd11:   return -5'sd8;
			4'd12:   return -5'sd8;
			4'd13:   return -5'sd7;
			4'd14:   return -5'sd5;
			default: return -5'sd2;
		endcase
	endfunction

	// Cosine of the carrier phase sector center, scaled by 8
	function automatic logic signed [4:0] cos_lut(input logic [TRIG_IDX_W-1:0] idx);
		case (idx)
			4'd0:    return 5'sd8;
			4'd1:    return 5'sd7;
			4'd2:    return 5'sd5;
			4'd3:    return 5'sd2;
			4'd4:    return -5'sd2;
			4'd5:    return -5'sd5;
			4'd6:    return -5'sd7;
			4'd7:    return -5'sd8;
			4'd8:    return -5'sd8;
			4'd9:    return -5'sd7;
			4'd10:   return -5'sd5;
			4'd11:   return -5'sd2;
			4'd12:   return 5'sd2;
			4'd13:   return 5'sd5;
			4'd14:   return 5'sd7;
			default: return 5'sd8;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gnss_code_carrier_correlator.sv
// One correlator channel: code and carrier NCOs, early-minus-late and prompt
// accumulators. Uses gccc_pkg, gccc_chip_mod and gccc_ram.
// A dump word leaves the output register after its wrapping sample passes stages 1 to 6.
// Throughput: one item per cycle when not stalled, set by the 64-bit code NCO update.
// The input stalls only while a dump word waits and the next wrap reaches the last stage.
// Reset (arst_n low) clears NCOs, accumulators, epoch counter and registers, but sets
// spacing to 16; code chips are not cleared and must be written before samples use them.
`default_nettype none

module gnss_code_carrier_correlator import gccc_pkg::*; #(
	parameter int unsigned CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// config write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input words
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// [3:0] sample, [17:4] chip_addr, [18] chip_value, [23:19] zero
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] command
	input  wire logic                   s_axis_tuser,
	// dump words
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [31:0] early_late_i, [63:32] early_late_q, [95:64] prompt_i,
	// [127:96] prompt_q, [144:128] epoch_count, [151:145] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int unsigned AW = $clog2(CODE_LENGTH);
	localparam logic [HI_W-1:0] PERIOD_256 = HI_W'(CODE_LENGTH << FRAC_BITS);
	localparam logic [AW-1:0] LAST_CHIP = AW'(CODE_LENGTH - 1);

	typedef struct packed {
		logic                         write;
		logic                         wrap;
		logic [EPOCH_W-1:0]           epoch;
		logic [TRIG_IDX_W-1:0]        tidx;
		logic signed [SAMPLE_W-1:0]   amp;
		logic [SUB_W-1:0]             sub;
		logic [CHIP_ADDR_W-1:0]       chip_addr;
		logic                         chip_value;
	} item_t;

	// configuration registers
	logic                   channel_enable_q;
	logic [ADC_W-1:0]       adc_mode_q;
	logic [GEO_W-1:0]       geo_class_q;
	logic [CARR_W-1:0]      carrier_word_q;
	logic [CODE_W-1:0]      code_word_q;
	logic [SPACING_W-1:0]   half_spacing_q;

	// channel state
	logic [PHASE_W-1:0]     code_phase_q;
	logic [CARR_W-1:0]      carrier_phase_q;
	logic [EPOCH_W-1:0]     epoch_q;
	logic [3:0][ACC_W-1:0]  acc_q;

	// pipeline
	logic                   adv;
	logic                   s1_valid_q;
	logic                   s1_cmd;
	logic signed [SAMPLE_W-1:0] s1_sample;
	logic [CHIP_ADDR_W-1:0] s1_chip_addr;
	logic                   s1_chip_value;
	logic                   s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, s6_valid_q;
	item_t                  s2_q, s3_q, s4_q, s5_q, s6_q;
	logic [CHIP_IDX_W-1:0]  s2_x;

	// output register
	logic                   out_valid_q;
	logic [3:0][ACC_W-1:0]  out_acc_q;
	logic [EPOCH_W-1:0]     out_epoch_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_enable_q <= 1'b0;
			adc_mode_q       <= '0;
			geo_class_q      <= '0;
			carrier_word_q   <= '0;
			code_word_q      <= '0;
			half_spacing_q   <= SPACING_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:  channel_enable_q <= cfg_data[0];
				REG_ADC:     adc_mode_q       <= cfg_data[ADC_W-1:0];
				REG_GEO:     geo_class_q      <= cfg_data[GEO_W-1:0];
				REG_CARRIER: carrier_word_q   <= cfg_data[CARR_W-1:0];
				REG_CODE:    code_word_q      <= cfg_data[CODE_W-1:0];
				REG_SPACING: half_spacing_q   <= cfg_data[SPACING_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stall control ----------------
	// freeze everything only when a dump word meets a full output register
	assign adv = !(s6_valid_q && s6_q.wrap && out_valid_q && !m_axis_tready);
	assign s_axis_tready = adv;

	// ---------------- stage 1: input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_cmd        <= s_axis_tuser;
			s1_sample     <= s_axis_tdata[SAMPLE_W-1:0];
			s1_chip_addr  <= s_axis_tdata[SAMPLE_W +: CHIP_ADDR_W];
			s1_chip_value <= s_axis_tdata[SAMPLE_W + CHIP_ADDR_W];
		end
	end

	// ---------------- stage 1: NCOs, epoch, quantizer ----------------
	logic                   s1_is_sample, s1_is_write;
	logic [PHASE_W-1:0]     phase_sum;
	logic [HI_W-1:0]        hi_raw, hi_new;
	logic                   wrap;
	logic [CARR_W:0]        carr_sum;
	logic [EPOCH_W-1:0]     epoch_next;
	logic [EPOCH_LO_W-1:0]  lo;
	logic [9:0]             hi_2ms;
	logic [6:0]             hi_1ms;
	logic signed [SAMPLE_W-1:0] amp;

	assign s1_is_sample = s1_valid_q && (s1_cmd == CMD_SAMPLE) && channel_enable_q;
	assign s1_is_write  = s1_valid_q && (s1_cmd == CMD_CHIP);

	// code NCO with one period of wrap
	assign phase_sum = code_phase_q + {1'b0, code_word_q};
	assign hi_raw    = phase_sum[PHASE_W-1:HI_W];
	assign wrap      = (hi_raw >= PERIOD_256);
	assign hi_new    = wrap ? hi_raw - PERIOD_256 : hi_raw;

	// carrier NCO
	assign carr_sum = {1'b0, carrier_phase_q} + {1'b0, carrier_word_q};

	// epoch counter step
	always_comb begin
		lo         = {1'b0, epoch_q[SUB_W-1:0]} + EPOCH_LO_W'(1);
		hi_2ms     = {1'b0, epoch_q[16:8]};
		hi_1ms     = {1'b0, epoch_q[13:8]};
		epoch_next = epoch_q;
		case (geo_class_q)
			GEO_2MS: begin
				if (lo >= LO_LIMIT_2MS) begin
					lo     = '0;
					hi_2ms = hi_2ms + 10'd1;
					if (hi_2ms >= HI_LIMIT_2MS) hi_2ms = '0;
				end
				epoch_next = {hi_2ms[8:0], 2'b00, lo};
			end
			GEO_1MS: begin
				if (lo >= LO_LIMIT_1MS) begin
					lo     = '0;
					hi_1ms = hi_1ms + 7'd1;
					if (hi_1ms >= HI_LIMIT_1MS) hi_1ms = '0;
				end
				epoch_next = {3'b000, hi_1ms[5:0], 2'b00, lo};
			end
			default: epoch_next = epoch_q;
		endcase
	end

	// sample quantizer
	always_comb begin
		case (adc_mode_q)
			ADC_ONE_BIT: amp = {3'b000, s1_sample[0]};
			ADC_TWO_BIT: begin
				if (s1_sample == -4'sd3 || s1_sample == -4'sd1 ||
						s1_sample == 4'sd1 || s1_sample == 4'sd3) begin
					amp = s1_sample;
				end else begin
					amp = -4'sd3;
				end
			end
			default: amp = s1_sample;
		endcase
	end

	// channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_phase_q    <= '0;
			carrier_phase_q <= '0;
			epoch_q         <= '0;
		end else if (adv && s1_is_sample) begin
			code_phase_q    <= {hi_new, phase_sum[HI_W-1:0]};
			carrier_phase_q <= carr_sum[CARR_W-1:0];
			if (wrap) epoch_q <= epoch_next;
		end
	end

	// ---------------- stages 2..5: chip index reduction ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
			s4_valid_q <= 1'b0;
			s5_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= s1_is_sample || s1_is_write;
			s3_valid_q <= s2_valid_q;
			s4_valid_q <= s3_valid_q;
			s5_valid_q <= s4_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_q.write      <= s1_is_write;
			s2_q.wrap       <= wrap;
			s2_q.epoch      <= epoch_next;
			s2_q.tidx       <= carr_sum[CARR_W-1 -: TRIG_IDX_W];
			s2_q.amp        <= amp;
			s2_q.sub        <= hi_new[FRAC_BITS-1 -: SUB_W];
			s2_q.chip_addr  <= s1_chip_addr;
			s2_q.chip_value <= s1_chip_value;
			s2_x            <= hi_new[HI_W-1:FRAC_BITS];
			s3_q            <= s2_q;
			s4_q            <= s3_q;
			s5_q            <= s4_q;
		end
	end

	logic [AW-1:0] chip_idx;

	gccc_chip_mod #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_chip_mod (
		.clk (clk),
		.en  (adv),
		.x   (s2_x),
		.rem (chip_idx)
	);

	// ---------------- stage 5: early/late addresses, code memory ----------------
	logic [SUB_W:0]  early_sum;
	logic            late_borrow;
	logic [AW-1:0]   addr_e, addr_l;
	logic            mem_we, mem_re;
	logic            chip_e, chip_p, chip_l;

	assign early_sum   = {1'b0, s5_q.sub} + {1'b0, half_spacing_q};
	assign late_borrow = (s5_q.sub < half_spacing_q);

	always_comb begin
		addr_e = chip_idx;
		if (early_sum[SUB_W]) begin
			addr_e = (chip_idx == LAST_CHIP) ? '0 : chip_idx + AW'(1);
		end
		addr_l = chip_idx;
		if (late_borrow) begin
			addr_l = (chip_idx == '0) ? LAST_CHIP : chip_idx - AW'(1);
		end
	end

	// chip writes go to all three copies in program order with the reads
	assign mem_we = adv && s5_valid_q && s5_q.write &&
		({1'b0, s5_q.chip_addr} < (CHIP_ADDR_W+1)'(CODE_LENGTH));
	assign mem_re = adv && s5_valid_q && !s5_q.write;

	gccc_ram #(.WIDTH(1), .DEPTH(CODE_LENGTH)) u_ram_early (
		.clk   (clk),
		.we    (mem_we),
		.waddr (s5_q.chip_addr[AW-1:0]),
		.wdata (s5_q.chip_value),
		.re    (mem_re),
		.raddr (addr_e),
		.rdata (chip_e)
	);

	gccc_ram #(.WIDTH(1), .DEPTH(CODE_LENGTH)) u_ram_prompt (
		.clk   (clk),
		.we    (mem_we),
		.waddr (s5_q.chip_addr[AW-1:0]),
		.wdata (s5_q.chip_value),
		.re    (mem_re),
		.raddr (chip_idx),
		.rdata (chip_p)
	);

	gccc_ram #(.WIDTH(1), .DEPTH(CODE_LENGTH)) u_ram_late (
		.clk   (clk),
		.we    (mem_we),
		.waddr (s5_q.chip_addr[AW-1:0]),
		.wdata (s5_q.chip_value),
		.re    (mem_re),
		.raddr (addr_l),
		.rdata (chip_l)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s6_valid_q <= 1'b0;
		end else if (adv) begin
			s6_valid_q <= s5_valid_q && !s5_q.write;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s6_q <= s5_q;
		end
	end

	// ---------------- stage 6: mix and accumulate ----------------
	logic signed [8:0]       ac, as;
	logic signed [ACC_W-1:0] ac32, as32;
	logic [3:0][ACC_W-1:0]   delta;
	logic [3:0][ACC_W-1:0]   acc_next;

	assign ac   = 9'(s6_q.amp) * 9'(cos_lut(s6_q.tidx));
	assign as   = 9'(s6_q.amp) * 9'(sin_lut(s6_q.tidx));
	assign ac32 = ACC_W'(ac);
	assign as32 = ACC_W'(as);

	always_comb begin
		// early-minus-late weight is 2*(late - early)
		case ({chip_e, chip_l})
			2'b01: begin
				delta[0] = -(ac32 <<< 1);
				delta[1] = as32 <<< 1;
			end
			2'b10: begin
				delta[0] = ac32 <<< 1;
				delta[1] = -(as32 <<< 1);
			end
			default: begin
				delta[0] = '0;
				delta[1] = '0;
			end
		endcase
		// prompt weight is -1 for a set chip
		delta[2] = chip_p ? ac32 : -ac32;
		delta[3] = chip_p ? -as32 : as32;
		for (int i = 0; i < 4; i++) begin
			acc_next[i] = (s6_q.wrap ? '0 : acc_q[i]) + delta[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && s6_valid_q) begin
			acc_q <= acc_next;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && s6_valid_q && s6_q.wrap) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s6_valid_q && s6_q.wrap) begin
			out_acc_q   <= acc_q;
			out_epoch_q <= s6_q.epoch;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - 4*ACC_W - EPOCH_W){1'b0}}, out_epoch_q,
		out_acc_q[3], out_acc_q[2], out_acc_q[1], out_acc_q[0]};

	// ---------------- checks ----------------
	// a dump word only appears behind a wrapping sample in the last stage
	a_dump_from_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s6_valid_q && s6_q.wrap))
		else $error("dump word without a code period wrap");

	// input back-pressure only while a dump word is held at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a waiting dump word");

	// reciprocal reduction always lands inside the code
	a_chip_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		s5_valid_q |-> ({1'b0, chip_idx} < (AW+1)'(CODE_LENGTH)))
		else $error("chip index reduction out of range");

	// accumulators hold while the pipeline is frozen
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(acc_q))
		else $error("accumulators changed during a stall");

endmodule

`default_nettype wire

// File: hw/rtl/gccc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module gccc_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/gccc_chip_mod.sv
// Three-stage reduction of a chip index modulo the code length
// (reciprocal multiply, back-multiply, one correcting subtract). Uses gccc_pkg.
`default_nettype none

module gccc_chip_mod import gccc_pkg::*; #(
	parameter int unsigned CODE_LENGTH = CODE_LENGTH_DEF,
	localparam int unsigned AW = $clog2(CODE_LENGTH)
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [CHIP_IDX_W-1:0] x,
	output logic      [AW-1:0]         rem
);

	localparam int unsigned RECIP_W = RECIP_SHIFT + 1 - $clog2(CODE_LENGTH);
	localparam int unsigned PROD_W  = CHIP_IDX_W + RECIP_W;
	localparam int unsigned QW      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / CODE_LENGTH);

	logic [PROD_W-1:0]     mult_s1;
	logic [CHIP_IDX_W-1:0] x_s1;
	logic [CHIP_IDX_W-1:0] back_s2;
	logic [CHIP_IDX_W-1:0] x_s2;
	logic [AW-1:0]         rem_s3;

	logic [QW-1:0]         quot;
	logic [CHIP_IDX_W-1:0] diff;
	logic [CHIP_IDX_W-1:0] fixed;

	// quotient estimate is exact or one short
	assign quot  = mult_s1[PROD_W-1:RECIP_SHIFT];
	assign diff  = x_s2 - back_s2;
	assign fixed = (diff >= CHIP_IDX_W'(CODE_LENGTH)) ? diff - CHIP_IDX_W'(CODE_LENGTH) : diff;

	always_ff @(posedge clk) begin
		if (en) begin
			mult_s1 <= PROD_W'(x) * PROD_W'(RECIP);
			x_s1    <= x;
			back_s2 <= CHIP_IDX_W'({{(CHIP_IDX_W-QW){1'b0}}, quot} * CHIP_IDX_W'(CODE_LENGTH));
			x_s2    <= x_s1;
			rem_s3  <= fixed[AW-1:0];
		end
	end

	assign rem = rem_s3;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for gnss_code_carrier_correlator: a directed table, then random
// phases with idling, a long receiver hold and an epoch rollover run, all checked by a model.
// Depends on gccc_pkg and the correlator RTL only.

module tb;
	import gccc_pkg::*;

	localparam int unsigned CHIPS       = CODE_LENGTH_DEF;
	localparam int unsigned PERIOD_256  = CHIPS * 256;	// code period in 1/256 chip
	localparam int unsigned PERIOD_32   = CHIPS * 32;	// code period in 1/32 chip
	localparam int          DRAIN       = 16;		// idle wait that lets the pipeline empty
	localparam int          STALL_LIMIT = 2000;
	localparam int          HOLD_CYCLES = 300;
	localparam logic [16:0] EP_LO_MASK  = 17'h0001F;
	localparam logic [16:0] EP_HI_2MS   = 17'h1FF00;
	localparam logic [16:0] EP_HI_1MS   = 17'h03F00;

	// carrier sector tables and early-minus-late weight by {early, prompt, late} chip bits
	localparam int SIN_TAB [16] = '{2, 5, 7, 8, 8, 7, 5, 2, -2, -5, -7, -8, -8, -7, -5, -2};
	localparam int COS_TAB [16] = '{8, 7, 5, 2, -2, -5, -7, -8, -8, -7, -5, -2, 2, 5, 7, 8};
	localparam int EL_TAB [8]   = '{0, 2, 0, 2, -2, 0, -2, 0};

	typedef struct packed {
		logic [16:0] epoch;
		logic [31:0] pq;
		logic [31:0] pi;
		logic [31:0] elq;
		logic [31:0] eli;
	} dump_t;

	typedef enum logic {ROW_REG, ROW_WORD} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		cfg_idx_t    idx;
		logic [62:0] val;
		cmd_t        cmd;
		logic [3:0]  smp;
		logic [13:0] addr;
		logic        cv;
		logic        typed;
		dump_t       want;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	cfg_idx_t               cfg_index = REG_ENABLE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	cmd_t                   s_axis_tuser = CMD_SAMPLE;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// channel settings as written
	logic        ch_enable = 1'b0;
	logic [1:0]  ch_adc = '0;
	logic [1:0]  ch_geo = '0;
	logic [29:0] ch_carrier_step = '0;
	logic [62:0] ch_code_step = '0;
	logic [4:0]  ch_spacing = 5'd16;

	// channel state
	logic [63:0] nco_code = '0;
	logic [29:0] nco_carrier = '0;
	logic [31:0] acc [4] = '{default: '0};
	logic [16:0] epoch_cnt = '0;
	logic        chip_mem [CHIPS];
	logic        epoch_rolled = 1'b0;

	dump_t dumps_due [$];
	row_t  rows [$];

	int mismatches = 0;
	int words_in = 0;
	int chip_writes = 0;
	int dumps_seen = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int held_cycles = 0;
	int idle_run = 0;

	gnss_code_carrier_correlator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// epoch counter: low count in bits 0..4, high count from bit 8
	function automatic void step_epoch();
		int unsigned lo, hi, lo_lim, hi_lim;
		logic [16:0] hi_mask;
		if (ch_geo == GEO_2MS) begin
			hi_mask = EP_HI_2MS;
			lo_lim  = 2;
			hi_lim  = 500;
		end else if (ch_geo == GEO_1MS) begin
			hi_mask = EP_HI_1MS;
			lo_lim  = 20;
			hi_lim  = 50;
		end else begin
			return;
		end
		lo = (epoch_cnt & EP_LO_MASK) + 1;
		hi = (epoch_cnt & hi_mask) >> 8;
		if (lo >= lo_lim) begin
			lo = 0;
			hi++;
			if (hi >= hi_lim) begin
				hi = 0;
				epoch_rolled = 1'b1;
			end
		end
		epoch_cnt = 17'((hi << 8) + lo);
	endfunction

	// one enabled sample: code NCO, dump on wrap, carrier NCO, correlate
	function automatic void correlate(input logic [3:0] raw);
		logic [31:0] hi, fine, early, late;
		logic [30:0] sum;
		logic [2:0]  k;
		logic [3:0]  tidx;
		int          a, sv, c, s, elw, pw;
		dump_t       d;
		nco_code = nco_code + {1'b0, ch_code_step};
		hi = nco_code[63:32];
		if (hi >= PERIOD_256) begin
			hi = hi - PERIOD_256;
			nco_code[63:32] = hi;
			d.eli = acc[0];
			d.elq = acc[1];
			d.pi  = acc[2];
			d.pq  = acc[3];
			acc = '{default: '0};
			step_epoch();
			d.epoch = epoch_cnt;
			dumps_due.push_back(d);
		end
		sum = {1'b0, nco_carrier} + {1'b0, ch_carrier_step};
		nco_carrier = sum[29:0];
		tidx = nco_carrier[29:26];
		// positions in 1/32 chip; a phase past the period folds for the lookup only
		fine = hi >> 3;
		if (fine >= PERIOD_32) fine = fine % PERIOD_32;
		early = fine + ch_spacing;
		if (early >= PERIOD_32) early = early - PERIOD_32;
		late = (fine >= ch_spacing) ? fine - ch_spacing : fine + PERIOD_32 - ch_spacing;
		k = {chip_mem[early >> 5], chip_mem[fine >> 5], chip_mem[late >> 5]};
		sv = $signed(raw);
		case (ch_adc)
			ADC_ONE_BIT: a = raw[0];
			ADC_TWO_BIT: a = (sv == -3 || sv == -1 || sv == 1 || sv == 3) ? sv : -3;
			default:     a = sv;
		endcase
		c   = COS_TAB[tidx];
		s   = SIN_TAB[tidx];
		elw = EL_TAB[k];
		pw  = k[1] ? -1 : 1;
		acc[0] = acc[0] - a * c * elw;
		acc[1] = acc[1] + a * s * elw;
		acc[2] = acc[2] - a * c * pw;
		acc[3] = acc[3] + a * s * pw;
	endfunction

	// offer one word; entered and left at a falling edge
	task automatic push_word(input cmd_t c, input logic [3:0] smp, input logic [13:0] addr,
			input logic cv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= {5'b0, cv, addr, smp};
		do @(posedge clk); while (!s_axis_tready);
		words_in++;
		if (c == CMD_CHIP) begin
			chip_writes++;
			if (addr < CHIPS) chip_mem[addr] = cv;
		end else if (ch_enable) begin
			correlate(smp);
		end
		@(negedge clk);
	endtask

	// drop valid, let every due dump arrive, then let the pipeline empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (dumps_due.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [62:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE:  ch_enable = val[0];
			REG_ADC:     ch_adc = val[1:0];
			REG_GEO:     ch_geo = val[1:0];
			REG_CARRIER: ch_carrier_step = val[29:0];
			REG_CODE:    ch_code_step = val;
			REG_SPACING: ch_spacing = val[4:0];
			default: ;
		endcase
	endtask

	function automatic void add_reg(input cfg_idx_t idx, input logic [62:0] val);
		row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx  = idx;
		r.val  = val;
		rows.push_back(r);
	endfunction

	// typed rows expect a dump of cleared accumulators with the given epoch
	function automatic void add_word(input cmd_t c, input logic [3:0] smp,
			input logic [13:0] addr = '0, input logic cv = 1'b0,
			input logic typed = 1'b0, input logic [16:0] ep = '0);
		row_t r;
		r = '0;
		r.kind  = ROW_WORD;
		r.cmd   = c;
		r.smp   = smp;
		r.addr  = addr;
		r.cv    = cv;
		r.typed = typed;
		r.want.epoch = ep;
		rows.push_back(r);
	endfunction

	// receiver: one long hold when asked, random stalls otherwise
	always @(negedge clk) begin
		if (held_cycles < hold_len) begin
			m_axis_tready <= 1'b0;
			held_cycles   <= held_cycles + 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// dump checker
	always @(posedge clk) begin : dump_check
		dump_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.eli   = m_axis_tdata[31:0];
			got.elq   = m_axis_tdata[63:32];
			got.pi    = m_axis_tdata[95:64];
			got.pq    = m_axis_tdata[127:96];
			got.epoch = m_axis_tdata[144:128];
			dumps_seen++;
			if (dumps_due.size() == 0) begin
				report_mismatch($sformatf("dump %0d arrived with none due", dumps_seen));
			end else begin
				want = dumps_due.pop_front();
				if (got.eli !== want.eli)
					report_mismatch($sformatf("dump %0d early_late_i %h, want %h",
						dumps_seen, got.eli, want.eli));
				if (got.elq !== want.elq)
					report_mismatch($sformatf("dump %0d early_late_q %h, want %h",
						dumps_seen, got.elq, want.elq));
				if (got.pi !== want.pi)
					report_mismatch($sformatf("dump %0d prompt_i %h, want %h",
						dumps_seen, got.pi, want.pi));
				if (got.pq !== want.pq)
					report_mismatch($sformatf("dump %0d prompt_q %h, want %h",
						dumps_seen, got.pq, want.pq));
				if (got.epoch !== want.epoch)
					report_mismatch($sformatf("dump %0d epoch_count %h, want %h",
						dumps_seen, got.epoch, want.epoch));
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_run <= 0;
		end else begin
			idle_run <= idle_run + 1;
			if (idle_run >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", idle_run);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		row_t        r;
		int          n0, ph;
		logic [62:0] cw;
		logic [13:0] addr;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// load the whole code first so no sample ever reads an unwritten chip
		for (int i = 0; i < CHIPS; i++)
			push_word(CMD_CHIP, 4'($urandom), 14'(i), 1'($urandom));

		// directed table
		add_word(CMD_SAMPLE, 4'h7);				// disabled after reset
		add_word(CMD_CHIP, 4'h0, 14'd10230, 1'b1);		// past the code, dropped
		add_word(CMD_CHIP, 4'hF, 14'h3FFF, 1'b0);
		add_reg(REG_ENABLE, 63'd1);
		add_reg(REG_CODE, 63'(PERIOD_256) << 32);		// wrap on every sample
		add_word(CMD_SAMPLE, 4'h8, '0, 1'b0, 1'b1, 17'h00001);	// one-bit, bit 0 clear
		add_word(CMD_SAMPLE, 4'h7, '0, 1'b0, 1'b1, 17'h00100);
		add_word(CMD_SAMPLE, 4'hF);
		add_reg(REG_ADC, 63'd1);
		add_word(CMD_SAMPLE, 4'h3);
		add_word(CMD_SAMPLE, 4'hD);
		add_word(CMD_SAMPLE, 4'h0);				// not a two-bit level
		add_word(CMD_SAMPLE, 4'h2);
		add_reg(REG_ADC, 63'd2);
		add_word(CMD_SAMPLE, 4'h8);
		add_word(CMD_SAMPLE, 4'h7);
		add_reg(REG_ADC, 63'd3);				// behaves as four-bit
		add_word(CMD_SAMPLE, 4'h9);
		add_reg(REG_CARRIER, 63'h3FFF_FFFF);
		add_word(CMD_SAMPLE, 4'h5);
		add_reg(REG_SPACING, 63'd0);
		add_word(CMD_SAMPLE, 4'hB);
		add_reg(REG_SPACING, 63'd31);
		add_word(CMD_SAMPLE, 4'h6);
		add_reg(REG_GEO, 63'd1);
		add_word(CMD_SAMPLE, 4'hC);
		add_reg(REG_GEO, 63'd2);
		add_word(CMD_SAMPLE, 4'h1);
		add_reg(REG_GEO, 63'd3);				// counter held
		add_word(CMD_SAMPLE, 4'hE);
		add_reg(REG_CODE, 63'h7FFF_FFFF_FFFF_FFFF);		// phase runs past the period
		add_word(CMD_SAMPLE, 4'h4);
		add_word(CMD_SAMPLE, 4'hA);
		add_reg(REG_ENABLE, 63'd0);
		add_word(CMD_SAMPLE, 4'h3);
		add_word(CMD_CHIP, 4'h0, 14'd0, 1'b1);
		add_word(CMD_CHIP, 4'h0, 14'd10229, 1'b0);
		add_reg(REG_ENABLE, 63'd1);
		add_reg(REG_CODE, 63'd0);				// zero step; the phase left past the period still wraps
		add_word(CMD_SAMPLE, 4'h7);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_REG) begin
				write_reg(r.idx, r.val);
			end else begin
				n0 = dumps_due.size();
				push_word(r.cmd, r.smp, r.addr, r.cv);
				if (r.typed && dumps_due.size() > n0)
					dumps_due[dumps_due.size() - 1] = r.want;
			end
		end

		// random phases, each under new settings and an idling pattern
		for (ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 62; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 62; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			write_reg(REG_ENABLE, (ph % 6 == 4) ? 63'd0 : 63'd1);
			write_reg(REG_ADC, 63'($urandom_range(0, 3)));
			write_reg(REG_GEO, 63'($urandom_range(0, 3)));
			case ($urandom_range(0, 3))
				0: write_reg(REG_CARRIER, 63'd0);
				1: write_reg(REG_CARRIER, 63'h3FFF_FFFF);
				default: write_reg(REG_CARRIER, 63'($urandom) & 63'h3FFF_FFFF);
			endcase
			case ($urandom_range(0, 5))
				3: cw = '1;
				4: cw = 63'({$urandom, $urandom});
				5: cw = (63'(PERIOD_256 + $urandom_range(0, 4000)) << 32) | 63'($urandom);
				default: cw = (63'(PERIOD_256 / $urandom_range(2, 50)) << 32) | 63'($urandom);
			endcase
			write_reg(REG_CODE, cw);
			write_reg(REG_SPACING, 63'($urandom_range(0, 31)));
			// back-pressure: wrap on every sample while the receiver holds off
			if (ph == 6) begin
				send_idle_pct = 0;
				write_reg(REG_CODE, (63'(PERIOD_256 + $urandom_range(1, 4000)) << 32)
					| 63'($urandom));
				hold_len = HOLD_CYCLES;
			end
			repeat (100) begin
				if ($urandom_range(0, 99) < 85) begin
					push_word(CMD_SAMPLE, 4'($urandom), 14'($urandom), 1'($urandom));
				end else begin
					addr = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(CHIPS, 16383))
						: 14'($urandom_range(0, CHIPS - 1));
					push_word(CMD_CHIP, 4'($urandom), addr, 1'($urandom));
				end
			end
		end

		// wrap on every sample in the two-ms class until the high count rolls over
		send_idle_pct = 12;
		stall_pct = 12;
		write_reg(REG_ENABLE, 63'd1);
		write_reg(REG_GEO, 63'd0);
		write_reg(REG_CODE, (63'(PERIOD_256 + $urandom_range(1, 3000)) << 32) | 63'($urandom));
		while (!epoch_rolled)
			push_word(CMD_SAMPLE, 4'($urandom), 14'($urandom), 1'($urandom));
		repeat (20) push_word(CMD_SAMPLE, 4'($urandom), 14'($urandom), 1'($urandom));

		settle();
		$display("run: %0d input words (%0d chip writes), %0d dumps checked", words_in,
			chip_writes, dumps_seen);
		$display("run: all adc modes and epoch classes, phase past period, %0d-cycle hold, "
			, HOLD_CYCLES, "epoch rollover %0s", epoch_rolled ? "reached" : "missed");
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
